// File: hw/rtl/rspc_pkg.sv
// Shared types, opcode constants and decode record for the successor PC unit.
package rspc_pkg;

    localparam int unsigned XLEN = 32;

    typedef logic [XLEN-1:0] word_t;

    // 32-bit major opcodes
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    // Compressed quadrants and funct3 codes
    localparam logic [1:0] QUAD_C1  = 2'b01;
    localparam logic [1:0] QUAD_C2  = 2'b10;
    localparam logic [1:0] QUAD_STD = 2'b11;

    localparam logic [2:0] F3_CJAL  = 3'b001;
    localparam logic [2:0] F3_CJ    = 3'b101;
    localparam logic [2:0] F3_CBEQZ = 3'b110;
    localparam logic [2:0] F3_CBNEZ = 3'b111;
    localparam logic [2:0] F3_CJR   = 3'b100;

    // c.jr / c.jalr: quadrant 10 with rs2 field zero
    localparam logic [15:0] CR_MASK = 16'h007F;
    localparam logic [15:0] CR_JUMP = 16'h0002;

    localparam logic [1:0] COUNT_ONE = 2'd1;
    localparam logic [1:0] COUNT_TWO = 2'd2;

    localparam word_t STEP_STD = word_t'(4);
    localparam word_t STEP_CMP = word_t'(2);

    // Operands for the two target adders, produced by the decoder
    typedef struct packed {
        word_t base0;        // pc or rs1 value
        word_t imm0;         // offset added to base0
        word_t imm1;         // offset added to pc for the taken branch
        logic  two_targets;  // conditional branch: both targets valid
        logic  clear_lsb;    // register-indirect jump: drop bit 0
    } dec_t;

endpackage

// File: hw/rtl/rspc_channels.sv
// Valid/ready channel interfaces for the successor PC unit.
interface rspc_in_if;
    import rspc_pkg::*;

    logic  valid;
    logic  ready;
    word_t pc;
    word_t instruction;
    word_t rs1_value;

    modport source (output valid, output pc, output instruction, output rs1_value,
                    input ready);
    modport sink   (input valid, input pc, input instruction, input rs1_value,
                    output ready);
endinterface

interface rspc_out_if;
    import rspc_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] target_count;
    word_t      first_target;
    word_t      second_target;

    modport source (output valid, output target_count, output first_target,
                    output second_target, input ready);
    modport sink   (input valid, input target_count, input first_target,
                    input second_target, output ready);
endinterface

// File: hw/rtl/rspc_decode.sv
// Instruction decoder: classifies the instruction and builds adder operands.
module rspc_decode
    import rspc_pkg::*;
(
    input  word_t pc,
    input  word_t instruction,
    input  word_t rs1_value,
    output dec_t  dec
);

    logic [15:0] half;
    logic [2:0]  c_f3;
    word_t       imm_j;
    word_t       imm_i;
    word_t       imm_b;
    word_t       imm_cj;
    word_t       imm_cb;

    assign half = instruction[15:0];
    assign c_f3 = half[15:13];

    assign imm_j  = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                     instruction[20], instruction[30:21], 1'b0};
    assign imm_i  = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_b  = {{19{instruction[31]}}, instruction[31], instruction[7],
                     instruction[30:25], instruction[11:8], 1'b0};
    assign imm_cj = {{20{half[12]}}, half[12], half[8], half[10:9], half[6],
                     half[7], half[2], half[11], half[5:3], 1'b0};
    assign imm_cb = {{23{half[12]}}, half[12], half[6:5], half[2], half[11:10],
                     half[4:3], 1'b0};

    always_comb
    begin
        dec.base0       = pc;
        dec.imm0        = STEP_CMP;
        dec.imm1        = '0;
        dec.two_targets = 1'b0;
        dec.clear_lsb   = 1'b0;

        if (instruction[1:0] == QUAD_STD)
        begin
            dec.imm0 = STEP_STD;
            priority if (instruction[6:0] == OPC_JAL)
            begin
                dec.imm0 = imm_j;
            end
            else if (instruction[6:0] == OPC_JALR)
            begin
                dec.base0     = rs1_value;
                dec.imm0      = imm_i;
                dec.clear_lsb = 1'b1;
            end
            else if (instruction[6:0] == OPC_BRANCH)
            begin
                dec.imm1        = imm_b;
                dec.two_targets = 1'b1;
            end
            else
            begin
                dec.imm0 = STEP_STD;
            end
        end
        else
        begin
            priority if (half[1:0] == QUAD_C1 && (c_f3 == F3_CJ || c_f3 == F3_CJAL))
            begin
                dec.imm0 = imm_cj;
            end
            else if (half[1:0] == QUAD_C1 && (c_f3 == F3_CBEQZ || c_f3 == F3_CBNEZ))
            begin
                dec.imm1        = imm_cb;
                dec.two_targets = 1'b1;
            end
            else if ((half & CR_MASK) == CR_JUMP && c_f3 == F3_CJR
                     && half[11:7] != 5'd0)
            begin
                // c.jr / c.jalr; rs1 zero falls through as c.ebreak or reserved
                dec.base0     = rs1_value;
                dec.imm0      = '0;
                dec.clear_lsb = 1'b1;
            end
            else
            begin
                dec.imm0 = STEP_CMP;
            end
        end
    end

endmodule

// File: hw/rtl/riscv_successor_pc_unit_top.sv
// Top level of the RV32IC successor PC unit: decode, add and output stages.
// An accepted input transaction passes the decode, adder and output registers in turn.
// Throughput: one transaction per cycle when not stalled; a full pipeline
// with a stalled output holds every stage, and the ready chain frees a stage
// once the stage behind it moves on, so bubbles are squeezed out under backpressure.
// Reset (rst_n low, asynchronous) clears the stage valid bits only.
module riscv_successor_pc_unit_top
    import rspc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    rspc_in_if.sink     instr_ch,
    rspc_out_if.source  target_ch
);

    // ------------------------------------------------------------------
    // Stage handshake: each stage advances when it is empty or when the
    // stage after it advances. The output register is the last stage.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || target_ch.ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign instr_ch.ready = rdy1;

    // ------------------------------------------------------------------
    // Stage 1: decode the instruction into adder operands.
    // ------------------------------------------------------------------
    dec_t  dec;
    dec_t  dec1_reg;
    word_t pc1_reg;

    rspc_decode u_decode (
        .pc          (instr_ch.pc),
        .instruction (instr_ch.instruction),
        .rs1_value   (instr_ch.rs1_value),
        .dec         (dec)
    );

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dec1_reg <= dec;
            pc1_reg  <= instr_ch.pc;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: both target adders, one 32-bit add each, wrapping mod 2^32.
    // ------------------------------------------------------------------
    word_t sum0_next, sum1_next;
    word_t sum0_reg, sum1_reg;
    logic  two2_reg, clr2_reg;

    assign sum0_next = dec1_reg.base0 + dec1_reg.imm0;
    assign sum1_next = pc1_reg + dec1_reg.imm1;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            sum0_reg <= sum0_next;
            sum1_reg <= sum1_next;
            two2_reg <= dec1_reg.two_targets;
            clr2_reg <= dec1_reg.clear_lsb;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: output register. Drop bit 0 for register-indirect jumps and
    // force the second target to zero when only one successor exists.
    // ------------------------------------------------------------------
    logic [1:0] count_next, count_reg;
    word_t      first_next, first_reg;
    word_t      second_next, second_reg;

    assign count_next  = two2_reg ? COUNT_TWO : COUNT_ONE;
    assign first_next  = {sum0_reg[XLEN-1:1], sum0_reg[0] & ~clr2_reg};
    assign second_next = two2_reg ? sum1_reg : '0;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= instr_ch.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign target_ch.valid         = v3_reg;
    assign target_ch.target_count  = count_reg;
    assign target_ch.first_target  = first_reg;
    assign target_ch.second_target = second_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A presented result always carries one or two targets.
    assert property (@(posedge clk) disable iff (!rst_n)
        target_ch.valid |-> (target_ch.target_count == COUNT_ONE ||
                             target_ch.target_count == COUNT_TWO))
        else $error("target_count out of range");

    // A single-successor result keeps the second target at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (target_ch.valid && target_ch.target_count == COUNT_ONE)
            |-> target_ch.second_target == '0)
        else $error("second_target not zero for single successor");

    // An accepted transaction occupies the decode stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (instr_ch.valid && instr_ch.ready) |=> v1_reg)
        else $error("accepted transaction lost at decode stage");

    // A full adder stage that cannot advance keeps its valid bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> v2_reg)
        else $error("stalled adder stage dropped its transaction");

endmodule
